>>> hw/rtl/nrt_pkg.sv
// Shared types, codes and defaults for the notification registration table.
package nrt_pkg;

  localparam int DEF_SLOTS_PER_CLIENT = 16;
  localparam int DEF_CLIENT_COUNT     = 8;

  localparam int CLIENT_W = 3;
  localparam int PEER_W   = 48;
  localparam int ATTR_W   = 16;
  localparam int MASK_W   = 8;
  localparam int STATUS_W = 2;

  localparam int QUEUE_DEPTH = 2;

  localparam logic CMD_REGISTER   = 1'b0;
  localparam logic CMD_DEREGISTER = 1'b1;

  localparam logic [STATUS_W-1:0] ST_SUCCESS   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ILLEGAL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_SLOT   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  // A classified request as it travels from the front end to the table engine.
  typedef struct packed {
    logic                illegal;
    logic                command;
    logic [CLIENT_W-1:0] client;
    logic [PEER_W-1:0]   peer;
    logic [ATTR_W-1:0]   attr;
  } nrt_req_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_LAST,
    BK_COMMIT
  } back_state_t;

endpackage

>>> hw/rtl/nrt_front.sv
// Front end: takes requests, holds the client mask and flags illegal requests.
module nrt_front #(
  parameter int CLIENT_COUNT = nrt_pkg::DEF_CLIENT_COUNT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [nrt_pkg::MASK_W-1:0]   cfg_data,
  input  logic                         cmd_valid,
  output logic                         cmd_stall,
  input  logic                         command,
  input  logic [nrt_pkg::CLIENT_W-1:0] client_index,
  input  logic [nrt_pkg::PEER_W-1:0]   peer_address,
  input  logic [nrt_pkg::ATTR_W-1:0]   attr_handle,
  output logic                         push,
  output nrt_pkg::nrt_req_t            push_req,
  input  logic                         queue_full
);
  import nrt_pkg::*;

  logic [MASK_W-1:0] client_mask;
  logic              client_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      client_mask <= '0;
    end else if (cfg_write) begin
      client_mask <= cfg_data;
    end
  end

  // A client beyond the configured count is never enabled.
  assign client_ok = (int'(client_index) < CLIENT_COUNT) && client_mask[client_index];

  assign cmd_stall = queue_full;
  assign push      = cmd_valid && !queue_full;

  always_comb begin
    push_req.illegal = (attr_handle == '0) || !client_ok;
    push_req.command = command;
    push_req.client  = client_index;
    push_req.peer    = peer_address;
    push_req.attr    = attr_handle;
  end

endmodule

>>> hw/rtl/nrt_queue.sv
// Short request queue between the front end and the table engine.
module nrt_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  nrt_pkg::nrt_req_t push_req,
  output logic              full,
  input  logic              pop,
  output nrt_pkg::nrt_req_t pop_req,
  output logic              empty
);
  import nrt_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  nrt_req_t           entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_req = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_req;
    end
  end

endmodule

>>> hw/rtl/nrt_back.sv
// Table engine: scans a client's slots in memory and applies the request.
module nrt_back #(
  parameter int SLOTS_PER_CLIENT = nrt_pkg::DEF_SLOTS_PER_CLIENT,
  parameter int CLIENT_COUNT     = nrt_pkg::DEF_CLIENT_COUNT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         queue_empty,
  input  nrt_pkg::nrt_req_t            queue_req,
  output logic                         pop,
  output logic                         res_valid,
  input  logic                         res_stall,
  output logic [nrt_pkg::STATUS_W-1:0] status
);
  import nrt_pkg::*;

  localparam int TOTAL  = CLIENT_COUNT * SLOTS_PER_CLIENT;
  localparam int SLOT_W = (SLOTS_PER_CLIENT > 1) ? $clog2(SLOTS_PER_CLIENT) : 1;
  localparam int ADDR_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int KEY_W  = PEER_W + ATTR_W;

  back_state_t state, state_next;

  nrt_req_t          req;
  logic [SLOT_W-1:0] cnt;
  logic              cmp_pend;
  logic [SLOT_W-1:0] cmp_slot;
  logic [KEY_W-1:0]  rd_data;
  logic              rd_vbit;
  logic              found;
  logic [SLOT_W-1:0] match_slot;
  logic              free_found;
  logic [SLOT_W-1:0] free_slot;

  logic [KEY_W-1:0]  mem [TOTAL];
  logic [TOTAL-1:0]  slot_valid;

  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] clr_addr;
  logic              can_load;
  logic              issue;
  logic              commit;
  logic              mem_we;
  logic              slot_clr;
  logic [STATUS_W-1:0] status_next;
  logic              cmp_hit;

  assign base     = ADDR_W'(int'(req.client) * SLOTS_PER_CLIENT);
  assign rd_addr  = base + ADDR_W'(cnt);
  assign wr_addr  = base + ADDR_W'(free_slot);
  assign clr_addr = base + ADDR_W'(match_slot);
  assign can_load = !res_valid || !res_stall;
  assign cmp_hit  = rd_vbit && (rd_data == {req.peer, req.attr});

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!queue_empty) begin
          state_next = queue_req.illegal ? BK_COMMIT : BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (cnt == SLOT_W'(SLOTS_PER_CLIENT - 1)) begin
          state_next = BK_LAST;
        end
      end
      BK_LAST:   state_next = BK_COMMIT;
      BK_COMMIT: begin
        if (can_load) begin
          state_next = BK_IDLE;
        end
      end
      default:   state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop         = 1'b0;
    issue       = 1'b0;
    commit      = 1'b0;
    mem_we      = 1'b0;
    slot_clr    = 1'b0;
    status_next = ST_SUCCESS;
    unique case (state)
      BK_IDLE:   pop = !queue_empty;
      BK_SCAN:   issue = 1'b1;
      BK_LAST:   issue = 1'b0;
      BK_COMMIT: commit = can_load;
      default:   pop = 1'b0;
    endcase
    if (req.illegal) begin
      status_next = ST_ILLEGAL;
    end else if (req.command == CMD_REGISTER) begin
      if (found) begin
        status_next = ST_SUCCESS;
      end else if (free_found) begin
        status_next = ST_SUCCESS;
        mem_we      = commit;
      end else begin
        status_next = ST_NO_SLOT;
      end
    end else begin
      if (found) begin
        status_next = ST_SUCCESS;
        slot_clr    = commit;
      end else begin
        status_next = ST_NOT_FOUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_IDLE;
      cmp_pend   <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
      res_valid  <= 1'b0;
      slot_valid <= '0;
    end else begin
      state    <= state_next;
      cmp_pend <= issue;
      if (pop) begin
        found      <= 1'b0;
        free_found <= 1'b0;
      end else if (cmp_pend) begin
        // The first match and the lowest free slot are both kept.
        if (cmp_hit) begin
          found <= 1'b1;
        end
        if (!rd_vbit) begin
          free_found <= 1'b1;
        end
      end
      if (commit) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      if (mem_we) begin
        slot_valid[wr_addr] <= 1'b1;
      end
      if (slot_clr) begin
        slot_valid[clr_addr] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      req <= queue_req;
      cnt <= '0;
    end else if (issue) begin
      cnt <= cnt + 1'b1;
    end
    if (issue) begin
      rd_vbit  <= slot_valid[rd_addr];
      cmp_slot <= cnt;
    end
    if (cmp_pend) begin
      if (cmp_hit && !found) begin
        match_slot <= cmp_slot;
      end
      if (!rd_vbit && !free_found) begin
        free_slot <= cmp_slot;
      end
    end
    if (commit) begin
      status <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= {req.peer, req.attr};
    end
    if (issue) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/notification_registration_table.sv
// Top level of the notification registration table.
//
// Each request names a client, a 48-bit peer address and a 16-bit attribute
// handle, and either registers or deregisters that subscription. Requests
// arrive on cmd_valid/cmd_stall; one status per request leaves on
// res_valid/res_stall, in request order. The user must write the client
// enable mask through cfg_write/cfg_data only while the block is idle; the
// block itself does not enforce this. The front end flags illegal requests
// (zero handle, client not enabled) and places every request in a two-entry
// queue. The table engine then reads the client's slots one per cycle from
// the slot memory and compares each against the key, so a table request's
// time in the engine grows with SLOTS_PER_CLIENT; an illegal one skips the
// scan. The engine takes no new request until it has committed the last one.
// The result register holds its status while res_stall is high; the queue
// keeps taking requests until it fills, and then cmd_stall rises.
// Reset clears the mask, the queue, the result valid flag and every slot's
// valid bit; slot contents are only read behind their valid bits.
module notification_registration_table #(
  parameter int SLOTS_PER_CLIENT = nrt_pkg::DEF_SLOTS_PER_CLIENT,
  parameter int CLIENT_COUNT     = nrt_pkg::DEF_CLIENT_COUNT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [nrt_pkg::MASK_W-1:0]   cfg_data,
  input  logic                         cmd_valid,
  output logic                         cmd_stall,
  input  logic                         command,
  input  logic [nrt_pkg::CLIENT_W-1:0] client_index,
  input  logic [nrt_pkg::PEER_W-1:0]   peer_address,
  input  logic [nrt_pkg::ATTR_W-1:0]   attr_handle,
  output logic                         res_valid,
  input  logic                         res_stall,
  output logic [nrt_pkg::STATUS_W-1:0] status
);
  import nrt_pkg::*;

  logic     push;
  nrt_req_t push_req;
  logic     queue_full;
  logic     pop;
  nrt_req_t pop_req;
  logic     queue_empty;

  nrt_front #(
    .CLIENT_COUNT(CLIENT_COUNT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .command      (command),
    .client_index (client_index),
    .peer_address (peer_address),
    .attr_handle  (attr_handle),
    .push         (push),
    .push_req     (push_req),
    .queue_full   (queue_full)
  );

  nrt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_req (push_req),
    .full     (queue_full),
    .pop      (pop),
    .pop_req  (pop_req),
    .empty    (queue_empty)
  );

  nrt_back #(
    .SLOTS_PER_CLIENT(SLOTS_PER_CLIENT),
    .CLIENT_COUNT    (CLIENT_COUNT)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .queue_req   (pop_req),
    .pop         (pop),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .status      (status)
  );

endmodule

>>> dv/nrt_status_check.sv
// Request and status monitor with a local subscription table that checks every status.
module nrt_status_check #(
  parameter int SLOTS_PER_CLIENT = nrt_pkg::DEF_SLOTS_PER_CLIENT,
  parameter int CLIENT_COUNT     = nrt_pkg::DEF_CLIENT_COUNT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [nrt_pkg::MASK_W-1:0]   cfg_data,
  input  logic                         cmd_valid,
  input  logic                         cmd_stall,
  input  logic                         command,
  input  logic [nrt_pkg::CLIENT_W-1:0] client_index,
  input  logic [nrt_pkg::PEER_W-1:0]   peer_address,
  input  logic [nrt_pkg::ATTR_W-1:0]   attr_handle,
  input  logic                         res_valid,
  input  logic                         res_stall,
  input  logic [nrt_pkg::STATUS_W-1:0] status,
  output int                           error_count,
  output int                           awaited_count
);
  import nrt_pkg::*;

  localparam int TOTAL_SLOTS = SLOTS_PER_CLIENT * CLIENT_COUNT;

  logic [MASK_W-1:0]   enable_mask;
  logic                slot_used [TOTAL_SLOTS];
  logic [PEER_W-1:0]   slot_peer [TOTAL_SLOTS];
  logic [ATTR_W-1:0]   slot_attr [TOTAL_SLOTS];
  logic [STATUS_W-1:0] awaited_status [$];
  int                  errors = 0;

  // Applies one request to the local table and returns the status it should produce.
  function automatic logic [STATUS_W-1:0] apply_subscription(
    input logic                cmd,
    input logic [CLIENT_W-1:0] client,
    input logic [PEER_W-1:0]   peer,
    input logic [ATTR_W-1:0]   attr
  );
    int base;
    int hit;
    int free_slot;
    int s;
    int k;
    hit       = -1;
    free_slot = -1;
    // The handle is checked before the client, for both commands.
    if (attr == '0) return ST_ILLEGAL;
    if (int'(client) >= CLIENT_COUNT || int'(client) >= MASK_W) return ST_ILLEGAL;
    if (!enable_mask[client]) return ST_ILLEGAL;
    base = int'(client) * SLOTS_PER_CLIENT;
    for (s = 0; s < SLOTS_PER_CLIENT; s++) begin
      k = base + s;
      if (hit < 0 && slot_used[k] && slot_peer[k] == peer && slot_attr[k] == attr) hit = k;
      if (free_slot < 0 && !slot_used[k]) free_slot = k;
    end
    if (cmd == CMD_REGISTER) begin
      if (hit >= 0) return ST_SUCCESS;
      if (free_slot < 0) return ST_NO_SLOT;
      slot_used[free_slot] = 1'b1;
      slot_peer[free_slot] = peer;
      slot_attr[free_slot] = attr;
      return ST_SUCCESS;
    end
    if (hit < 0) return ST_NOT_FOUND;
    slot_used[hit] = 1'b0;
    slot_peer[hit] = '0;
    slot_attr[hit] = '0;
    return ST_SUCCESS;
  endfunction

  always @(posedge clk) begin : status_watch
    logic [STATUS_W-1:0] want;
    int i;
    if (rst) begin
      enable_mask = '0;
      for (i = 0; i < TOTAL_SLOTS; i++) slot_used[i] = 1'b0;
      awaited_status.delete();
    end else begin
      if (cfg_write) enable_mask = cfg_data;
      if (res_valid === 1'b1 && res_stall === 1'b0) begin
        if (awaited_status.size() == 0) begin
          $error("status %0d returned with no request outstanding", status);
          errors++;
        end else begin
          want = awaited_status.pop_front();
          if (status !== want) begin
            $error("status mismatch: expected %0d, actual %0d", want, status);
            errors++;
          end
        end
      end
      if (cmd_valid === 1'b1 && cmd_stall === 1'b0)
        awaited_status.push_back(
          apply_subscription(command, client_index, peer_address, attr_handle));
    end
    error_count   <= errors;
    awaited_count <= awaited_status.size();
  end

endmodule

>>> dv/notification_registration_table_tb.sv
// Stimulus, clocking and final verdict for the notification registration table.
module notification_registration_table_tb;
  import nrt_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 30;

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                cfg_write    = 1'b0;
  logic [MASK_W-1:0]   cfg_data     = '0;
  logic                cmd_valid    = 1'b0;
  logic                command      = CMD_REGISTER;
  logic [CLIENT_W-1:0] client_index = '0;
  logic [PEER_W-1:0]   peer_address = '0;
  logic [ATTR_W-1:0]   attr_handle  = '0;
  logic                res_stall    = 1'b0;
  logic                cmd_stall;
  logic                res_valid;
  logic [STATUS_W-1:0] status;
  logic                idle_on      = 1'b1;
  int                  error_count;
  int                  awaited_count;

  // A small pool of keys so that duplicates, matches and full tables are common.
  logic [PEER_W-1:0]   peer_pool [5];
  logic [ATTR_W-1:0]   attr_pool [4];

  notification_registration_table #(
    .SLOTS_PER_CLIENT(DEF_SLOTS_PER_CLIENT),
    .CLIENT_COUNT    (DEF_CLIENT_COUNT)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .command     (command),
    .client_index(client_index),
    .peer_address(peer_address),
    .attr_handle (attr_handle),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .status      (status)
  );

  nrt_status_check #(
    .SLOTS_PER_CLIENT(DEF_SLOTS_PER_CLIENT),
    .CLIENT_COUNT    (DEF_CLIENT_COUNT)
  ) u_status_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .command      (command),
    .client_index (client_index),
    .peer_address (peer_address),
    .attr_handle  (attr_handle),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .status       (status),
    .error_count  (error_count),
    .awaited_count(awaited_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin : result_backpressure
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left == 0 && idle_on && $urandom_range(0, 4) == 0)
        stall_left = $urandom_range(1, 8);
      if (stall_left > 0) begin
        res_stall <= 1'b1;
        stall_left--;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((cmd_valid && cmd_stall === 1'b0) || (res_valid === 1'b1 && !res_stall)) quiet = 0;
      else quiet++;
    end
    $error("nothing accepted for %0d cycles", WATCHDOG_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // Presents one request and returns at the edge where it is taken.
  task automatic send_request(
    input logic                cmd,
    input logic [CLIENT_W-1:0] client,
    input logic [PEER_W-1:0]   peer,
    input logic [ATTR_W-1:0]   attr
  );
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid    <= 1'b1;
    command      <= cmd;
    client_index <= client;
    peer_address <= peer;
    attr_handle  <= attr;
    @(posedge clk);
    while (cmd_stall !== 1'b0) @(posedge clk);
  endtask

  task automatic drain_results();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (awaited_count != 0) @(posedge clk);
  endtask

  task automatic write_mask(input logic [MASK_W-1:0] mask);
    cfg_write <= 1'b1;
    cfg_data  <= mask;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic run_random(input int count, input bit phase_idles);
    int                  i;
    int                  pick;
    int                  key;
    logic                cmd;
    logic [CLIENT_W-1:0] client;
    logic [PEER_W-1:0]   peer;
    logic [ATTR_W-1:0]   attr;
    for (i = 0; i < count; i++) begin
      // Every third stretch of 32 requests runs without gaps or stalls.
      idle_on <= phase_idles && ((i / 32) % 3 != 2);
      cmd = ($urandom_range(0, 99) < 66) ? CMD_REGISTER : CMD_DEREGISTER;
      // At least half the requests go to clients 0 and 1 so that their tables fill up.
      client = $urandom_range(0, 1) ? CLIENT_W'($urandom_range(0, 1))
                                    : CLIENT_W'($urandom_range(0, 7));
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        key  = $urandom_range(0, 19);
        peer = peer_pool[key / 4];
        attr = attr_pool[key % 4];
      end else begin
        peer = PEER_W'({$urandom(), $urandom()});
        attr = (pick < 95) ? ATTR_W'($urandom()) : '0;
      end
      send_request(cmd, client, peer, attr);
    end
  endtask

  initial begin : stimulus
    int i;
    for (i = 0; i < 5; i++) peer_pool[i] = {8'(i), 32'($urandom()), 8'($urandom())};
    for (i = 0; i < 4; i++) attr_pool[i] = {12'($urandom()), 4'(i + 1)};

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // No client is enabled out of reset.
    send_request(CMD_REGISTER, 3'd0, peer_pool[0], attr_pool[0]);
    drain_results();
    write_mask(8'hFF);

    send_request(CMD_REGISTER, 3'd2, peer_pool[1], '0);
    send_request(CMD_DEREGISTER, 3'd2, peer_pool[1], '0);
    send_request(CMD_REGISTER, 3'd7, '1, '1);
    send_request(CMD_REGISTER, 3'd7, '1, '1);
    send_request(CMD_REGISTER, 3'd7, '0, 16'd1);
    send_request(CMD_DEREGISTER, 3'd7, '1, '1);
    send_request(CMD_DEREGISTER, 3'd7, '1, '1);
    // Client 3 is filled from the pool; the request after that finds no free slot.
    for (i = 0; i <= DEF_SLOTS_PER_CLIENT; i++)
      send_request(CMD_REGISTER, 3'd3, peer_pool[i / 4], attr_pool[i % 4]);

    run_random(120, 1'b1);
    drain_results();
    write_mask(MASK_W'($urandom_range(1, 254)));
    run_random(100, 1'b1);
    drain_results();
    write_mask(8'h00);
    run_random(30, 1'b1);
    drain_results();
    write_mask(8'h5A);
    run_random(80, 1'b1);
    drain_results();
    write_mask(8'hFF);
    run_random(120, 1'b0);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && awaited_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
